// ===== rtl/core/i2cmts_pkg.sv =====
// Package for the I2C master transaction sequencer: beat types, kind codes, byte item lookup.
`default_nettype none

package i2cmts_pkg;

	localparam int HoldW = 10;
	localparam logic [HoldW-1:0] HOLD_RESET = 10'd4;

	localparam logic [2:0] KIND_WORD_WR     = 3'd0;
	localparam logic [2:0] KIND_WORD_RD     = 3'd1;
	localparam logic [2:0] KIND_BYTE_WR     = 3'd2;
	localparam logic [2:0] KIND_BYTE_RD     = 3'd3;
	localparam logic [2:0] KIND_SINGLE_WR   = 3'd4;
	localparam logic [2:0] KIND_CUR_WORD_RD = 3'd5;
	localparam logic [2:0] KIND_REPEAT_WR   = 3'd6;
	localparam logic [2:0] KIND_CUR_BYTE_RD = 3'd7;

	typedef struct packed {
		logic        mode;
		logic [2:0]  kind;
		logic [7:0]  device_address;
		logic [7:0]  address_high;
		logic [7:0]  address_low;
		logic [15:0] write_data;
		logic        sda_in;
	} cmd_t;

	typedef struct packed {
		logic        scl;
		logic        sda_drive;
		logic        sda_output_enable;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		logic       rd;
		logic       restart;
		logic       last;
		logic       high;
		logic [7:0] val;
	} item_t;

	// byte item idx of a transaction of the given kind
	function automatic item_t item_at(input logic [2:0] kind, input logic [7:0] dev,
			input logic [7:0] ah, input logic [7:0] al, input logic [15:0] wd,
			input logic [2:0] idx);
		item_t      it;
		logic [7:0] dp;
		logic [7:0] lo;
		logic [7:0] hi;
		it = '0;
		it.valid = 1'b1;
		dp = dev + 8'd1;
		lo = wd[7:0];
		hi = wd[15:8];
		unique case (kind)
			KIND_WORD_WR: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx == 3'd1) it.val = ah;
				else if (idx == 3'd2) it.val = al;
				else if (idx == 3'd3) it.val = lo;
				else if (idx == 3'd4) it.val = hi;
				else it.valid = 1'b0;
			end
			KIND_WORD_RD: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx == 3'd1) it.val = ah;
				else if (idx == 3'd2) it.val = al;
				else if (idx == 3'd3) begin
					it.val = dp;
					it.restart = 1'b1;
				end else if (idx == 3'd4) it.rd = 1'b1;
				else if (idx == 3'd5) begin
					it.rd = 1'b1;
					it.last = 1'b1;
					it.high = 1'b1;
				end else it.valid = 1'b0;
			end
			KIND_BYTE_WR: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx == 3'd1) it.val = al;
				else if (idx == 3'd2) it.val = lo;
				else it.valid = 1'b0;
			end
			KIND_BYTE_RD: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx == 3'd1) it.val = al;
				else if (idx == 3'd2) begin
					it.val = dp;
					it.restart = 1'b1;
				end else if (idx == 3'd3) begin
					it.rd = 1'b1;
					it.last = 1'b1;
				end else it.valid = 1'b0;
			end
			KIND_SINGLE_WR: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx == 3'd1) it.val = al;
				else it.valid = 1'b0;
			end
			KIND_CUR_WORD_RD: begin
				if (idx == 3'd0) it.val = dp;
				else if (idx == 3'd1) begin
					it.rd = 1'b1;
					it.high = 1'b1;
				end else if (idx == 3'd2) begin
					it.rd = 1'b1;
					it.last = 1'b1;
				end else it.valid = 1'b0;
			end
			KIND_REPEAT_WR: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx <= 3'd4) it.val = lo;
				else it.valid = 1'b0;
			end
			KIND_CUR_BYTE_RD: begin
				if (idx == 3'd0) it.val = dev;
				else if (idx == 3'd1) begin
					it.rd = 1'b1;
					it.last = 1'b1;
				end else it.valid = 1'b0;
			end
			default: it.valid = 1'b0;
		endcase
		return it;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/i2cmts_core.sv =====
// Bus sequencer: phase machine, hold counter, shifter and per-beat result.
`default_nettype none

module i2cmts_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire i2cmts_pkg::cmd_t             beat,
	input  wire logic [i2cmts_pkg::HoldW-1:0] hold_cfg,
	output i2cmts_pkg::rsp_t                  result
);
	import i2cmts_pkg::*;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_ST0    = 4'd1;
	localparam logic [3:0] PH_ST1    = 4'd2;
	localparam logic [3:0] PH_ST2    = 4'd3;
	localparam logic [3:0] PH_ST3    = 4'd4;
	localparam logic [3:0] PH_BIT_LO = 4'd5;
	localparam logic [3:0] PH_BIT_HI = 4'd6;
	localparam logic [3:0] PH_ACK_LO = 4'd7;
	localparam logic [3:0] PH_ACK_HI = 4'd8;
	localparam logic [3:0] PH_SP0    = 4'd9;
	localparam logic [3:0] PH_SP1    = 4'd10;
	localparam logic [3:0] PH_SP2    = 4'd11;

	logic [3:0]       phase_q, phase_n;
	logic [HoldW-1:0] delay_q, delay_n, delay_inc, hold;
	logic [3:0]       bit_q, bit_n, bit_inc;
	logic [2:0]       idx_q, idx_n, idx_inc;
	logic [7:0]       shift_q, shift_n;
	logic [2:0]       kind_q, kind_n;
	logic [7:0]       dev_q, dev_n, ah_q, ah_n, al_q, al_n;
	logic [15:0]      wd_q, wd_n, rword_q, rword_n;
	logic             done_n;
	item_t            cur_it, nx_it, out_it;

	assign hold      = (hold_cfg == '0) ? HoldW'(1) : hold_cfg;
	assign delay_inc = delay_q + HoldW'(1);
	assign bit_inc   = bit_q + 4'd1;
	assign idx_inc   = idx_q + 3'd1;
	assign cur_it    = item_at(kind_q, dev_q, ah_q, al_q, wd_q, idx_q);
	assign nx_it     = item_at(kind_q, dev_q, ah_q, al_q, wd_q, idx_inc);
	assign out_it    = item_at(kind_n, dev_n, ah_n, al_n, wd_n, idx_n);

	always_comb begin
		phase_n = phase_q;
		delay_n = delay_q;
		bit_n   = bit_q;
		idx_n   = idx_q;
		shift_n = shift_q;
		kind_n  = kind_q;
		dev_n   = dev_q;
		ah_n    = ah_q;
		al_n    = al_q;
		wd_n    = wd_q;
		rword_n = rword_q;
		done_n  = 1'b0;
		if (accept) begin
			if (beat.mode) begin
				if (phase_q == PH_IDLE) begin
					kind_n  = beat.kind;
					dev_n   = beat.device_address;
					ah_n    = beat.address_high;
					al_n    = beat.address_low;
					wd_n    = beat.write_data;
					if (beat.kind == KIND_WORD_RD || beat.kind == KIND_BYTE_RD ||
							beat.kind == KIND_CUR_WORD_RD || beat.kind == KIND_CUR_BYTE_RD)
						rword_n = '0;
					phase_n = PH_ST0;
					delay_n = '0;
					bit_n   = '0;
					idx_n   = '0;
					shift_n = '0;
				end
			end else if (phase_q != PH_IDLE) begin
				if (delay_inc >= hold) begin
					delay_n = '0;
					unique case (phase_q)
						PH_ST0:    phase_n = PH_ST1;
						PH_ST1:    phase_n = PH_ST2;
						PH_ST2:    phase_n = PH_ST3;
						PH_ST3: begin
							bit_n   = '0;
							shift_n = cur_it.rd ? 8'd0 : cur_it.val;
							phase_n = PH_BIT_LO;
						end
						PH_BIT_LO: phase_n = PH_BIT_HI;
						PH_BIT_HI: begin
							shift_n = {shift_q[6:0], cur_it.rd & beat.sda_in};
							bit_n   = bit_inc;
							phase_n = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
						end
						PH_ACK_LO: phase_n = PH_ACK_HI;
						PH_ACK_HI: begin
							if (cur_it.rd) begin
								if (cur_it.high) rword_n = {shift_q, rword_q[7:0]};
								else rword_n = {rword_q[15:8], shift_q};
							end
							idx_n = idx_inc;
							if (!nx_it.valid) phase_n = PH_SP0;
							else if (nx_it.restart) phase_n = PH_ST0;
							else begin
								bit_n   = '0;
								shift_n = nx_it.rd ? 8'd0 : nx_it.val;
								phase_n = PH_BIT_LO;
							end
						end
						PH_SP0:    phase_n = PH_SP1;
						PH_SP1:    phase_n = PH_SP2;
						PH_SP2: begin
							phase_n = PH_IDLE;
							done_n  = 1'b1;
						end
						default:   phase_n = PH_IDLE;
					endcase
				end else begin
					delay_n = delay_inc;
				end
			end
		end
	end

	always_comb begin
		result.scl               = 1'b1;
		result.sda_drive         = 1'b1;
		result.sda_output_enable = 1'b1;
		result.busy_res          = (phase_n != PH_IDLE);
		result.done_res          = done_n;
		result.read_data         = rword_n;
		unique case (phase_n)
			PH_ST0: begin
				result.scl = 1'b0;
				result.sda_drive = 1'b1;
			end
			PH_ST1: begin
				result.scl = 1'b1;
				result.sda_drive = 1'b1;
			end
			PH_ST2: begin
				result.scl = 1'b1;
				result.sda_drive = 1'b0;
			end
			PH_ST3: begin
				result.scl = 1'b0;
				result.sda_drive = 1'b0;
			end
			PH_BIT_LO, PH_BIT_HI: begin
				result.scl = (phase_n == PH_BIT_HI);
				if (out_it.rd) begin
					result.sda_drive = 1'b1;
					result.sda_output_enable = 1'b0;
				end else begin
					result.sda_drive = shift_n[7];
				end
			end
			PH_ACK_LO, PH_ACK_HI: begin
				result.scl = (phase_n == PH_ACK_HI);
				result.sda_drive = out_it.rd & out_it.last;
			end
			PH_SP0: begin
				result.scl = 1'b0;
				result.sda_drive = 1'b0;
			end
			PH_SP1: begin
				result.scl = 1'b1;
				result.sda_drive = 1'b0;
			end
			PH_SP2: begin
				result.scl = 1'b1;
				result.sda_drive = 1'b1;
			end
			default: begin
				result.scl = 1'b1;
				result.sda_drive = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= '0;
			bit_q   <= '0;
			idx_q   <= '0;
			shift_q <= '0;
			kind_q  <= '0;
			dev_q   <= '0;
			ah_q    <= '0;
			al_q    <= '0;
			wd_q    <= '0;
			rword_q <= '0;
		end else begin
			phase_q <= phase_n;
			delay_q <= delay_n;
			bit_q   <= bit_n;
			idx_q   <= idx_n;
			shift_q <= shift_n;
			kind_q  <= kind_n;
			dev_q   <= dev_n;
			ah_q    <= ah_n;
			al_q    <= al_n;
			wd_q    <= wd_n;
			rword_q <= rword_n;
		end
	end

`ifndef SYNTH
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'd8)
		else $error("bit counter past eight");
	a_idle_delay: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> delay_q == '0)
		else $error("hold counter running while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_n |=> phase_q == PH_IDLE && $past(phase_q) == PH_SP2)
		else $error("done without stop completion");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_transaction_sequencer_top.sv =====
// Top level of the I2C master transaction sequencer: APB register, skid output stage, core.
//
//  channel | direction | handshake               | beat
//  cmd     | in        | cmd_valid / cmd_stall   | cmd_beat (i2cmts_pkg::cmd_t)
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_beat (i2cmts_pkg::rsp_t)
//  apb     | in        | psel, penable, pwrite   | paddr, pwdata, prdata; pready tied high
//
// One cmd beat per cycle unless cmd_stall; its rsp beat is registered in the output stage.
// The sequencer state and result logic sit in one combinational pass ahead of that stage.
// Reset puts the bus idle (SCL and SDA high) with half_period_ticks = 4.
// A two-entry output stage (register plus skid) absorbs rsp_stall; cmd_stall is
// the registered skid-full flag.
`default_nettype none

module i2c_master_transaction_sequencer_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire i2cmts_pkg::cmd_t  cmd_beat,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output i2cmts_pkg::rsp_t       rsp_beat,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import i2cmts_pkg::*;

	localparam logic REG_HALF_PERIOD = 1'b0;

	logic [HoldW-1:0] hold_q;
	logic             accept, take;
	rsp_t             core_rsp, res_q, skid_q;
	logic             res_valid_q, skid_full_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HALF_PERIOD) ? {{(32-HoldW){1'b0}}, hold_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_HALF_PERIOD) begin
			hold_q <= pwdata[HoldW-1:0];
		end
	end

	assign cmd_stall = skid_full_q;
	assign accept    = cmd_valid && !skid_full_q;
	assign take      = res_valid_q && !rsp_stall;
	assign rsp_valid = res_valid_q;
	assign rsp_beat  = res_q;

	i2cmts_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.beat     (cmd_beat),
		.hold_cfg (hold_q),
		.result   (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) skid_full_q <= 1'b0;
		end else if (accept) begin
			if (!res_valid_q || take) res_valid_q <= 1'b1;
			else skid_full_q <= 1'b1;
		end else if (take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) res_q <= skid_q;
		end else if (accept) begin
			if (!res_valid_q || take) res_q <= core_rsp;
			else skid_q <= core_rsp;
		end
	end

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> res_valid_q)
		else $error("skid entry without output entry");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(res_valid_q && rsp_stall && cmd_valid))
		else $error("skid filled while output was free");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.done_res |-> !rsp_beat.busy_res)
		else $error("done reported while busy");
`endif

endmodule

`default_nettype wire
